FILE: hdl/sth_pkg.sv
// ----------------------------------------------------------------------------
// sth_pkg
// Shared widths, codes, coefficient record and the log2 fraction table for the
// Steinhart-Hart thermistor converter.
// ----------------------------------------------------------------------------
package sth_pkg;

	// input and table geometry
	localparam int R_BITS   = 24;
	localparam int LB       = 8;
	localparam int TAB_SIZE = (1 << LB) + 1;
	localparam int TAB_W    = 29;
	localparam int FRAC_W   = 31;
	localparam int IDX_W    = LB;
	localparam int REM_W    = FRAC_W - LB;
	localparam int P_W      = 5;
	localparam int IN_W     = 24;

	// log and power widths
	localparam int LG_W     = 34;
	localparam int LN2C_W   = 30;
	localparam logic [LN2C_W-1:0] LN2_Q30 = 30'd744261118;
	localparam int LN_W     = 30;
	localparam int LNSQ_W   = 36;
	localparam int LNCU_W   = 42;

	// coefficient arithmetic
	localparam int COEF_W   = 48;
	localparam int HALF_W   = COEF_W / 2;
	localparam int MAG_W    = 64;
	localparam int RECIP_W  = 64;

	// divider and output
	localparam int Q_W      = 22;
	localparam int DIV_W    = RECIP_W + Q_W;
	localparam int C_W      = 25;
	localparam int TEMP_W   = 17;
	localparam int TDATA_W  = 24;
	localparam logic signed [C_W-1:0] ZERO_C_Q12  = 25'sd1118822;
	localparam logic signed [C_W-1:0] LOW_LIM_Q12 = -25'sd204800;
	localparam logic signed [C_W-1:0] HIGH_LIM_Q12 = 25'sd1024000;
	localparam logic signed [C_W-1:0] ROUND_OFS  = 25'sd204808;
	localparam logic signed [TEMP_W-1:0] TEMP_OFS = 17'sd12800;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_C = 2'd2;

	localparam logic [COEF_W-1:0] COEF_A_RST = 48'd317790000000;
	localparam logic [COEF_W-1:0] COEF_B_RST = 48'd65892000000;
	localparam logic [COEF_W-1:0] COEF_C_RST = 48'd24699000;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_LOW  = 2'd1,
		STAT_HIGH = 2'd2
	} sth_status_t;

	// per-stage control that travels with each item
	typedef struct packed {
		logic        valid;
		sth_status_t status;
	} sth_ctl_t;

	// coefficients, b and c held as sign and magnitude
	typedef struct packed {
		logic [COEF_W-1:0] a;
		logic              b_neg;
		logic [COEF_W-1:0] b_mag;
		logic              c_neg;
		logic [COEF_W-1:0] c_mag;
	} sth_coef_t;

	typedef logic [TAB_W-1:0] lg_tab_t [0:TAB_SIZE-1];

	// log2(1 + i/2^LB) in Q.28 by truncated repeated squaring in Q.30
	function automatic lg_tab_t lg_build();
		lg_tab_t t;
		logic [63:0] x;
		logic [TAB_W-1:0] acc;
		for (int i = 0; i < TAB_SIZE; i++) begin
			x = (64'd1 << 30) + (64'(i) << (30 - LB));
			acc = '0;
			for (int k = 27; k >= 0; k--) begin
				x = (x * x) >> 30;
				if (x >= (64'd2 << 30)) begin
					acc[k] = 1'b1;
					x = x >> 1;
				end
			end
			if (i == TAB_SIZE - 1)
				t[i] = TAB_W'(1) << 28;
			else
				t[i] = acc;
		end
		return t;
	endfunction

	localparam lg_tab_t LG_TABLE = lg_build();

endpackage

FILE: hdl/sth_log.sv
// ----------------------------------------------------------------------------
// sth_log
// Natural log of the resistance in Q.24: leading-one search, table lookup with
// linear interpolation, scaling by ln 2. Four register stages.
// ----------------------------------------------------------------------------
module sth_log (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [sth_pkg::IN_W-1:0]      in_r,
	output sth_pkg::sth_ctl_t             out_ctl,
	output logic [sth_pkg::LN_W-1:0]      out_ln
);

	logic [sth_pkg::R_BITS-1:0] r;
	logic [sth_pkg::P_W-1:0]    p;
	logic [31:0]                shifted;

	sth_pkg::sth_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [sth_pkg::P_W-1:0]    p_s1, p_s2;
	logic [sth_pkg::FRAC_W-1:0] frac_s1;
	logic [sth_pkg::TAB_W-1:0]  t0_s2, diff_s2;
	logic [sth_pkg::REM_W-1:0]  rem_s2;
	logic [sth_pkg::LG_W-1:0]   lg_s3;
	logic [sth_pkg::LN_W-1:0]   ln_s4;

	logic [sth_pkg::IDX_W-1:0]  idx;
	logic [sth_pkg::IDX_W:0]    nxt;
	logic [sth_pkg::TAB_W+sth_pkg::REM_W-1:0] interp_p;
	logic [sth_pkg::LG_W-1:0]   lg;
	logic [sth_pkg::LG_W+sth_pkg::LN2C_W-1:0] ln_p;

	// leading one and normalized mantissa
	always_comb begin
		r = in_r[sth_pkg::R_BITS-1:0];
		p = '0;
		for (int i = 0; i < sth_pkg::R_BITS; i++)
			if (r[i]) p = sth_pkg::P_W'(i);
		shifted = 32'(r) << (5'd31 - p);
	end

	// table reads
	assign idx = frac_s1[sth_pkg::FRAC_W-1 -: sth_pkg::IDX_W];
	assign nxt = {1'b0, idx} + 1'b1;

	// interpolation and ln 2 scaling
	assign interp_p = diff_s2 * rem_s2;
	assign lg = (sth_pkg::LG_W'(p_s2) << 28) + sth_pkg::LG_W'(t0_s2)
		+ sth_pkg::LG_W'(interp_p >> sth_pkg::REM_W);
	assign ln_p = lg_s3 * sth_pkg::LN2_Q30;

	// valid and status chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s1.valid  <= in_valid;
			ctl_s1.status <= (r == '0) ? sth_pkg::STAT_LOW : sth_pkg::STAT_OK;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= p;
			frac_s1 <= shifted[sth_pkg::FRAC_W-1:0];
			p_s2    <= p_s1;
			t0_s2   <= sth_pkg::LG_TABLE[{1'b0, idx}];
			diff_s2 <= sth_pkg::LG_TABLE[nxt] - sth_pkg::LG_TABLE[{1'b0, idx}];
			rem_s2  <= frac_s1[sth_pkg::REM_W-1:0];
			lg_s3   <= lg;
			ln_s4   <= ln_p[sth_pkg::LG_W+sth_pkg::LN2C_W-1 -: sth_pkg::LN_W];
		end
	end

	assign out_ctl = ctl_s4;
	assign out_ln  = ln_s4;

endmodule

FILE: hdl/sth_poly.sv
// ----------------------------------------------------------------------------
// sth_poly
// Reciprocal kelvin a + b*lnR + c*lnR^3 at scale 2^-48. Coefficient products
// are split into two 24-bit halves. Five register stages.
// ----------------------------------------------------------------------------
module sth_poly (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  sth_pkg::sth_coef_t            coef,
	input  sth_pkg::sth_ctl_t             in_ctl,
	input  logic [sth_pkg::LN_W-1:0]      in_ln,
	output sth_pkg::sth_ctl_t             out_ctl,
	output logic [sth_pkg::RECIP_W-1:0]   out_recip
);

	localparam int BP_W = sth_pkg::HALF_W + sth_pkg::LN_W;
	localparam int CP_W = sth_pkg::HALF_W + sth_pkg::LNCU_W;

	sth_pkg::sth_ctl_t ctl_s5, ctl_s6, ctl_s7, ctl_s8, ctl_s9;
	logic [sth_pkg::LN_W-1:0]    ln_s5;
	logic [sth_pkg::LNSQ_W-1:0]  lnsq_s5;
	logic [BP_W-1:0]             bl_s5, bh_s5;
	logic [sth_pkg::LNCU_W-1:0]  lncu_s6;
	logic [sth_pkg::MAG_W-1:0]   bmag_s6, bmag_s7, bmag_s8;
	logic [CP_W-1:0]             cl_s7, ch_s7;
	logic [sth_pkg::MAG_W-1:0]   cmag_s8;
	logic [sth_pkg::RECIP_W-1:0] recip_s9;

	logic [2*sth_pkg::LN_W-1:0]                 sq_p;
	logic [sth_pkg::LNSQ_W+sth_pkg::LN_W-1:0]   cu_p;
	logic [sth_pkg::MAG_W-1:0]                  bs, cs, a_ext;

	// squares and cubes of ln R
	assign sq_p = in_ln * in_ln;
	assign cu_p = lnsq_s5 * ln_s5;

	// signed terms
	assign a_ext = {{(sth_pkg::RECIP_W-sth_pkg::COEF_W){coef.a[sth_pkg::COEF_W-1]}}, coef.a};
	assign bs = coef.b_neg ? -bmag_s8 : bmag_s8;
	assign cs = coef.c_neg ? -cmag_s8 : cmag_s8;

	// valid and status chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
			ctl_s9 <= '0;
		end else if (en) begin
			ctl_s5 <= in_ctl;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
			ctl_s9 <= ctl_s8;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			ln_s5    <= in_ln;
			lnsq_s5  <= sq_p[2*sth_pkg::LN_W-1 -: sth_pkg::LNSQ_W];
			bl_s5    <= coef.b_mag[sth_pkg::HALF_W-1:0] * in_ln;
			bh_s5    <= coef.b_mag[sth_pkg::COEF_W-1:sth_pkg::HALF_W] * in_ln;
			lncu_s6  <= cu_p[sth_pkg::LNSQ_W+sth_pkg::LN_W-1 -: sth_pkg::LNCU_W];
			bmag_s6  <= sth_pkg::MAG_W'(bh_s5) + sth_pkg::MAG_W'(bl_s5 >> sth_pkg::HALF_W);
			cl_s7    <= coef.c_mag[sth_pkg::HALF_W-1:0] * lncu_s6;
			ch_s7    <= coef.c_mag[sth_pkg::COEF_W-1:sth_pkg::HALF_W] * lncu_s6;
			bmag_s7  <= bmag_s6;
			cmag_s8  <= sth_pkg::MAG_W'(ch_s7) + sth_pkg::MAG_W'(cl_s7 >> sth_pkg::HALF_W);
			bmag_s8  <= bmag_s7;
			recip_s9 <= a_ext + bs + cs;
		end
	end

	assign out_ctl   = ctl_s9;
	assign out_recip = recip_s9;

endmodule

FILE: hdl/sth_div.sv
// ----------------------------------------------------------------------------
// sth_div
// Rounded 2^60 / recip by a restoring divider, one quotient bit per stage,
// then Celsius offset, range check and 1/256 degree rounding.
// ----------------------------------------------------------------------------
module sth_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  sth_pkg::sth_ctl_t             in_ctl,
	input  logic [sth_pkg::RECIP_W-1:0]   in_recip,
	output logic                          out_valid,
	output logic [sth_pkg::TEMP_W-1:0]    out_temp,
	output sth_pkg::sth_status_t          out_status
);

	sth_pkg::sth_ctl_t                ctl_s [0:sth_pkg::Q_W];
	logic [sth_pkg::DIV_W-1:0]        rem_s [0:sth_pkg::Q_W];
	logic [sth_pkg::RECIP_W-1:0]      d_s   [0:sth_pkg::Q_W];
	logic [sth_pkg::Q_W-1:0]          q_s   [0:sth_pkg::Q_W];

	logic [sth_pkg::RECIP_W-1:0] num;
	logic                        big;
	sth_pkg::sth_status_t        st0;
	logic signed [sth_pkg::C_W-1:0] c12, sum;
	sth_pkg::sth_status_t        st_f;
	logic                        valid_q;
	logic [sth_pkg::TEMP_W-1:0]  temp_q;
	sth_pkg::sth_status_t        status_q;

	// numerator with half divisor for rounding; quotient past 2^Q_W is out of range
	assign num = (sth_pkg::RECIP_W'(1) << 60) + (in_recip >> 1);
	assign big = {{sth_pkg::Q_W{1'b0}}, num} >= {in_recip, {sth_pkg::Q_W{1'b0}}};

	// sign, zero and quotient overflow of the reciprocal
	always_comb begin
		st0 = in_ctl.status;
		if (in_ctl.status == sth_pkg::STAT_OK) begin
			if (in_recip[sth_pkg::RECIP_W-1])
				st0 = sth_pkg::STAT_LOW;
			else if (in_recip == '0)
				st0 = sth_pkg::STAT_HIGH;
			else if (big)
				st0 = sth_pkg::STAT_HIGH;
		end
	end

	// divider entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0].valid  <= in_ctl.valid;
			ctl_s[0].status <= st0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= sth_pkg::DIV_W'(num);
			d_s[0]   <= in_recip;
			q_s[0]   <= '0;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 0; j < sth_pkg::Q_W; j++) begin : g_div
		localparam int B = sth_pkg::Q_W - 1 - j;
		logic [sth_pkg::DIV_W-1:0] dsh;
		logic                      ge;

		assign dsh = sth_pkg::DIV_W'(d_s[j]) << B;
		assign ge  = rem_s[j] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[j+1] <= '0;
			end else if (en) begin
				ctl_s[j+1] <= ctl_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= ge ? rem_s[j] - dsh : rem_s[j];
				d_s[j+1]    <= d_s[j];
				q_s[j+1]    <= q_s[j] | (sth_pkg::Q_W'(ge) << B);
			end
		end
	end

	// celsius offset and range check
	assign c12 = sth_pkg::C_W'(q_s[sth_pkg::Q_W]) - sth_pkg::ZERO_C_Q12;
	assign sum = c12 + sth_pkg::ROUND_OFS;

	always_comb begin
		st_f = ctl_s[sth_pkg::Q_W].status;
		if (st_f == sth_pkg::STAT_OK) begin
			if (c12 < sth_pkg::LOW_LIM_Q12)
				st_f = sth_pkg::STAT_LOW;
			else if (c12 > sth_pkg::HIGH_LIM_Q12)
				st_f = sth_pkg::STAT_HIGH;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= ctl_s[sth_pkg::Q_W].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_q <= st_f;
			if (st_f == sth_pkg::STAT_OK)
				temp_q <= sth_pkg::TEMP_W'(sum >>> 4) - sth_pkg::TEMP_OFS;
			else
				temp_q <= '0;
		end
	end

	assign out_valid  = valid_q;
	assign out_temp   = temp_q;
	assign out_status = status_q;

endmodule

FILE: hdl/thermistor_steinhart_hart_top.sv
// ----------------------------------------------------------------------------
// thermistor_steinhart_hart_top
// Thermistor resistance to Celsius through the Steinhart-Hart equation.
// ----------------------------------------------------------------------------
// Takes one resistance per clock and returns one temperature per resistance,
// in order: 4 stages form ln R, 5 stages evaluate the polynomial, and the 24
// remaining stages are the reciprocal divider (one quotient bit per stage)
// with the output register. The whole pipeline holds while a result waits on
// m_axis_tready, so throughput is one item per cycle whenever the output side
// takes results. Coefficients are written through the cfg channel, which is
// always ready, and must only change while the pipeline is empty. Status 1
// means short or below -50 C, status 2 means open or above 250 C, and
// temperature then reads zero.
module thermistor_steinhart_hart_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [sth_pkg::IN_W-1:0]         s_axis_tdata,  // resistance_ohms
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [sth_pkg::TDATA_W-1:0]      m_axis_tdata,  // temperature, zero pad
	output logic [1:0]                       m_axis_tuser,  // status
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sth_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sth_pkg::COEF_W-1:0]       cfg_data
);

	logic                           en;
	sth_pkg::sth_coef_t             coef_q;
	sth_pkg::sth_ctl_t              log_ctl, poly_ctl;
	logic [sth_pkg::LN_W-1:0]       ln;
	logic [sth_pkg::RECIP_W-1:0]    recip;
	logic                           out_valid;
	logic [sth_pkg::TEMP_W-1:0]     out_temp;
	sth_pkg::sth_status_t           out_status;

	// pipeline advances unless the output holds an untaken result
	assign en            = ~out_valid | m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;

	// coefficient registers, b and c kept as sign and magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.a     <= sth_pkg::COEF_A_RST;
			coef_q.b_neg <= 1'b0;
			coef_q.b_mag <= sth_pkg::COEF_B_RST;
			coef_q.c_neg <= 1'b0;
			coef_q.c_mag <= sth_pkg::COEF_C_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				sth_pkg::CFG_COEF_A: begin
					coef_q.a <= cfg_data;
				end
				sth_pkg::CFG_COEF_B: begin
					coef_q.b_neg <= cfg_data[sth_pkg::COEF_W-1];
					coef_q.b_mag <= cfg_data[sth_pkg::COEF_W-1] ? -cfg_data : cfg_data;
				end
				sth_pkg::CFG_COEF_C: begin
					coef_q.c_neg <= cfg_data[sth_pkg::COEF_W-1];
					coef_q.c_mag <= cfg_data[sth_pkg::COEF_W-1] ? -cfg_data : cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// ln R
	sth_log u_log (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_axis_tvalid),
		.in_r     (s_axis_tdata),
		.out_ctl  (log_ctl),
		.out_ln   (ln)
	);

	// reciprocal kelvin
	sth_poly u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.coef      (coef_q),
		.in_ctl    (log_ctl),
		.in_ln     (ln),
		.out_ctl   (poly_ctl),
		.out_recip (recip)
	);

	// divide, offset and range check
	sth_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_ctl     (poly_ctl),
		.in_recip   (recip),
		.out_valid  (out_valid),
		.out_temp   (out_temp),
		.out_status (out_status)
	);

	assign m_axis_tvalid = out_valid;
	assign m_axis_tdata  = sth_pkg::TDATA_W'(out_temp);
	assign m_axis_tuser  = out_status;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression bench for the Steinhart-Hart thermistor converter: resistances
// stream in under random bursts and output stalls, and each temperature and
// status is checked against a bit-exact fixed-point prediction.
// ----------------------------------------------------------------------------

// predicts temperature and status for each accepted resistance
class temp_scoreboard;
	logic [28:0]  log2_frac [0:256];
	longint       k_a, k_b, k_c;
	logic [23:0]  temp_q [$];
	logic [1:0]   stat_q [$];
	int           errors;
	int           checked;
	int           stat_seen [0:3];

	function new();
		longint unsigned x;
		logic [28:0] acc;
		for (int i = 0; i <= 256; i++) begin
			x = (64'd1 << 30) + (64'(i) << 22);
			acc = '0;
			for (int k = 27; k >= 0; k--) begin
				x = (x * x) >> 30;
				if (x >= (64'd2 << 30)) begin
					acc[k] = 1'b1;
					x = x >> 1;
				end
			end
			log2_frac[i] = (i == 256) ? (29'd1 << 28) : acc;
		end
		errors = 0;
		checked = 0;
		foreach (stat_seen[i]) stat_seen[i] = 0;
		set_coef(sth_pkg::CFG_COEF_A, 48'd317790000000);
		set_coef(sth_pkg::CFG_COEF_B, 48'd65892000000);
		set_coef(sth_pkg::CFG_COEF_C, 48'd24699000);
	endfunction

	function void set_coef(logic [1:0] idx, logic [47:0] val);
		longint s;
		s = longint'({{16{val[47]}}, val});
		case (idx)
			sth_pkg::CFG_COEF_A: k_a = s;
			sth_pkg::CFG_COEF_B: k_b = s;
			sth_pkg::CFG_COEF_C: k_c = s;
			default: ;
		endcase
	endfunction

	// signed coefficient times Q.24 value, >> 24 toward zero
	function longint coef_times(longint coef, longint unsigned v);
		logic neg;
		longint unsigned mag;
		logic [127:0] prod;
		neg = coef < 0;
		mag = neg ? longint'(-coef) : coef;
		prod = {64'd0, mag} * {64'd0, v};
		return neg ? -longint'(prod[87:24]) : longint'(prod[87:24]);
	endfunction

	function void note_resistance(logic [23:0] r);
		int p;
		longint unsigned frac, rem, idx, diff, lg, ln, lnsq, lncu, kel;
		longint recip, cel, temp;
		sth_pkg::sth_status_t st;
		temp = 0;
		st = sth_pkg::STAT_OK;
		if (r == 0) begin
			st = sth_pkg::STAT_LOW;
		end else begin
			p = 23;
			while (p > 0 && !r[p]) p--;
			frac = (64'(r) << (31 - p)) & 64'h7FFF_FFFF;
			idx = frac >> 23;
			rem = frac & 64'h7F_FFFF;
			diff = 64'(log2_frac[idx + 1]) - 64'(log2_frac[idx]);
			lg = (64'(p) << 28) + 64'(log2_frac[idx]) + ((diff * rem) >> 23);
			ln = (lg * 64'd744261118) >> 34;
			lnsq = (ln * ln) >> 24;
			lncu = (lnsq * ln) >> 24;
			recip = k_a + coef_times(k_b, ln) + coef_times(k_c, lncu);
			if (recip < 0) begin
				st = sth_pkg::STAT_LOW;
			end else if (recip == 0) begin
				st = sth_pkg::STAT_HIGH;
			end else begin
				kel = ((64'd1 << 60) + (longint'(recip) >> 1)) / longint'(recip);
				cel = longint'(kel) - 1118822;
				if (cel < -204800)
					st = sth_pkg::STAT_LOW;
				else if (cel > 1024000)
					st = sth_pkg::STAT_HIGH;
				else
					temp = ((cel + 204800 + 8) >>> 4) - 12800;
			end
		end
		temp_q.push_back({7'd0, temp[16:0]});
		stat_q.push_back(st);
	endfunction

	function void check_result(logic [23:0] tdata, logic [1:0] tuser);
		logic [23:0] et;
		logic [1:0]  es;
		if (temp_q.size() == 0) begin
			$error("unexpected result transaction: tdata %h status %0d", tdata, tuser);
			errors++;
			return;
		end
		et = temp_q.pop_front();
		es = stat_q.pop_front();
		checked++;
		stat_seen[es]++;
		if (tdata !== et) begin
			$error("temperature mismatch: expected %0d actual %0d (tdata %h)",
				$signed(et[16:0]), $signed(tdata[16:0]), tdata);
			errors++;
		end
		if (tuser !== es) begin
			$error("status mismatch: expected %0d actual %0d", es, tuser);
			errors++;
		end
	endfunction
endclass

module tb;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [47:0] cfg_data = '0;

	temp_scoreboard sb = new();
	int burst_left = 0;
	int idle_cycles = 0;
	int sent = 0;
	int cfg_writes = 0;
	int stall_mode = 0;

	thermistor_steinhart_hart_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// receiver stall pattern, mode changes at random
	always @(negedge clk) begin
		if ($urandom_range(0, 299) == 0) stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 1) == 1);
			2: m_axis_tready <= ($urandom_range(0, 7) == 0);
			default: m_axis_tready <= ($urandom_range(0, 15) != 0);
		endcase
	end

	// result check and watchdog
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			sb.check_result(m_axis_tdata, m_axis_tuser);
			idle_cycles = 0;
		end else if ((s_axis_tvalid && s_axis_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= 3000) begin
				$display("watchdog: no transaction for %0d cycles", idle_cycles);
				$display("thermistor_steinhart_hart_top regression: fail");
				$finish;
			end
		end
	end

	task automatic send_resistance(input logic [23:0] r);
		if (burst_left == 0) begin
			if ($urandom_range(0, 2) != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, 25)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= r;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_resistance(r);
		sent++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.temp_q.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_coef(input logic [1:0] idx, input logic [47:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_coef(idx, val);
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// mostly log-spread thermistor values, some full-range and zero
	function automatic logic [23:0] pick_resistance();
		int nb;
		logic [23:0] r;
		case ($urandom_range(0, 9))
			0: r = 24'($urandom_range(0, 24'hFFFFFF));
			1: r = ($urandom_range(0, 3) == 0) ? 24'd0
				: 24'(24'hFFFFFF - $urandom_range(0, 255));
			default: begin
				nb = $urandom_range(1, 24);
				r = 24'(($urandom & ((32'd1 << (nb - 1)) - 1)) | (32'd1 << (nb - 1)));
			end
		endcase
		return r;
	endfunction

	function automatic logic [47:0] near_coef(input longint base, input int spread);
		longint d;
		d = longint'($urandom) << $urandom_range(0, spread);
		return 48'($urandom_range(0, 1) ? base + d : base - d);
	endfunction

	task automatic random_items(input int n);
		repeat (n) send_resistance(pick_resistance());
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed: reset coefficients, edges of the resistance range
		send_resistance(24'd0);
		send_resistance(24'd1);
		send_resistance(24'd2);
		send_resistance(24'd3);
		send_resistance(24'hFFFFFF);
		send_resistance(24'h800000);
		send_resistance(24'h7FFFFF);
		send_resistance(24'h555555);
		send_resistance(24'hAAAAAA);
		send_resistance(24'd10000);
		send_resistance(24'd100);
		send_resistance(24'd300);
		send_resistance(24'd500000);
		send_resistance(24'd1000000);
		send_resistance(24'd32768);
		random_items(600);
		drain();

		// all coefficients zero gives a zero reciprocal
		write_coef(sth_pkg::CFG_COEF_A, 48'd0);
		write_coef(sth_pkg::CFG_COEF_B, 48'd0);
		write_coef(sth_pkg::CFG_COEF_C, 48'd0);
		send_resistance(24'd10000);
		send_resistance(24'd1);
		drain();

		// negative constant term gives a negative reciprocal
		write_coef(sth_pkg::CFG_COEF_A, 48'h800000000000);
		send_resistance(24'd10000);
		send_resistance(24'hFFFFFF);
		drain();

		// register extremes
		write_coef(sth_pkg::CFG_COEF_A, 48'h7FFFFFFFFFFF);
		write_coef(sth_pkg::CFG_COEF_B, 48'h800000000000);
		write_coef(sth_pkg::CFG_COEF_C, 48'h7FFFFFFFFFFF);
		random_items(100);
		drain();
		write_coef(sth_pkg::CFG_COEF_A, 48'h000000000001);
		write_coef(sth_pkg::CFG_COEF_B, 48'h7FFFFFFFFFFF);
		write_coef(sth_pkg::CFG_COEF_C, 48'h800000000000);
		random_items(80);
		drain();

		// coefficients scattered around a realistic thermistor fit
		repeat (6) begin
			write_coef(sth_pkg::CFG_COEF_A, near_coef(317790000000, 6));
			write_coef(sth_pkg::CFG_COEF_B, near_coef(65892000000, 4));
			write_coef(sth_pkg::CFG_COEF_C, near_coef(24699000, 0));
			random_items(100);
			drain();
		end

		// back to the reset fit
		write_coef(sth_pkg::CFG_COEF_A, 48'd317790000000);
		write_coef(sth_pkg::CFG_COEF_B, 48'd65892000000);
		write_coef(sth_pkg::CFG_COEF_C, 48'd24699000);
		random_items(150);
		drain();

		$display("covered %0d resistances, %0d coefficient writes, %0d results checked",
			sent, cfg_writes, sb.checked);
		$display("status mix: valid %0d, low %0d, high %0d",
			sb.stat_seen[0], sb.stat_seen[1], sb.stat_seen[2]);
		if (sb.errors == 0 && sb.temp_q.size() == 0) begin
			$display("thermistor_steinhart_hart_top regression: pass");
		end else begin
			$display("thermistor_steinhart_hart_top regression: fail");
		end
		$finish;
	end
endmodule
